// ----- sv/cts_pkg.sv -----
`timescale 1ns / 1ps
// cts_pkg: shared types and codes for the css token scanner
// lexer modes, token codes, character codes and result structs; no dependencies

package cts_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'd0,
		MODE_WS    = 4'd1,
		MODE_DQ    = 4'd2,
		MODE_SQ    = 4'd3,
		MODE_HASH  = 4'd4,
		MODE_AT    = 4'd5,
		MODE_NUM   = 4'd6,
		MODE_UNIT  = 4'd7,
		MODE_IDENT = 4'd8,
		MODE_PDOT  = 4'd9,
		MODE_PHASH = 4'd10
	} mode_t;

	typedef enum logic [4:0] {
		TOK_WS     = 5'd0,
		TOK_STR    = 5'd1,
		TOK_BAD    = 5'd2,
		TOK_HASH   = 5'd3,
		TOK_AT     = 5'd4,
		TOK_NUM    = 5'd5,
		TOK_PCT    = 5'd6,
		TOK_DIM    = 5'd7,
		TOK_IDENT  = 5'd8,
		TOK_FUNC   = 5'd9,
		TOK_LBRACE = 5'd10,
		TOK_RBRACE = 5'd11,
		TOK_LPAREN = 5'd12,
		TOK_RPAREN = 5'd13,
		TOK_LBRACK = 5'd14,
		TOK_RBRACK = 5'd15,
		TOK_COLON  = 5'd16,
		TOK_SEMI   = 5'd17,
		TOK_COMMA  = 5'd18,
		TOK_DELIM  = 5'd19,
		TOK_EOF    = 5'd20
	} tok_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	// one result item
	typedef struct packed {
		logic       kind;
		tok_t       ttype;
		logic [7:0] ch;
		logic       last;
	} res_t;

	// decode of one request: up to two results and the next mode
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
		mode_t      next_mode;
	} dec_t;

endpackage

// ----- sv/cts_decode.sv -----
`timescale 1ns / 1ps
// cts_decode: combinational lexer step for one byte or end of input
// gives up to two results and the next mode; uses cts_pkg

module cts_decode (
	input  cts_pkg::mode_t mode,
	input  logic [7:0]     byte_value,
	input  logic           end_of_input,
	output cts_pkg::dec_t  dec
);

	typedef struct packed {
		logic           emit;
		cts_pkg::res_t  res;
		cts_pkg::mode_t mode;
	} idle_t;

	function automatic logic is_ws(logic [7:0] c);
		return c == cts_pkg::CH_SPACE || (c >= cts_pkg::CH_TAB && c <= cts_pkg::CH_CR);
	endfunction

	function automatic logic is_dig(logic [7:0] c);
		return c >= cts_pkg::CH_0 && c <= cts_pkg::CH_9;
	endfunction

	function automatic logic is_start(logic [7:0] c);
		return (c >= cts_pkg::CH_UA && c <= cts_pkg::CH_UZ) ||
			(c >= cts_pkg::CH_LA && c <= cts_pkg::CH_LZ) ||
			c == cts_pkg::CH_UNDER || c == cts_pkg::CH_MINUS;
	endfunction

	function automatic logic is_name(logic [7:0] c);
		return is_start(c) || is_dig(c);
	endfunction

	function automatic cts_pkg::res_t mk(logic kind, cts_pkg::tok_t t, logic [7:0] c);
		cts_pkg::res_t r;
		r.kind  = kind;
		r.ttype = t;
		r.ch    = c;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic cts_pkg::res_t chr(logic [7:0] c);
		return mk(1'b0, cts_pkg::TOK_WS, c);
	endfunction

	function automatic cts_pkg::res_t evt(cts_pkg::tok_t t);
		return mk(1'b1, t, cts_pkg::CH_NUL);
	endfunction

	// scan a byte from the idle mode
	function automatic idle_t scan_idle(logic [7:0] c);
		idle_t s;
		s.emit = 1'b1;
		s.mode = cts_pkg::MODE_IDLE;
		s.res  = mk(1'b1, cts_pkg::TOK_DELIM, c);
		case (c)
			cts_pkg::CH_DQUOTE: begin s.emit = 1'b0; s.mode = cts_pkg::MODE_DQ;    end
			cts_pkg::CH_SQUOTE: begin s.emit = 1'b0; s.mode = cts_pkg::MODE_SQ;    end
			cts_pkg::CH_HASH:   begin s.emit = 1'b0; s.mode = cts_pkg::MODE_PHASH; end
			cts_pkg::CH_AT:     begin s.emit = 1'b0; s.mode = cts_pkg::MODE_AT;    end
			cts_pkg::CH_DOT:    begin s.emit = 1'b0; s.mode = cts_pkg::MODE_PDOT;  end
			cts_pkg::CH_LBRACE: s.res = evt(cts_pkg::TOK_LBRACE);
			cts_pkg::CH_RBRACE: s.res = evt(cts_pkg::TOK_RBRACE);
			cts_pkg::CH_LPAREN: s.res = evt(cts_pkg::TOK_LPAREN);
			cts_pkg::CH_RPAREN: s.res = evt(cts_pkg::TOK_RPAREN);
			cts_pkg::CH_LBRACK: s.res = evt(cts_pkg::TOK_LBRACK);
			cts_pkg::CH_RBRACK: s.res = evt(cts_pkg::TOK_RBRACK);
			cts_pkg::CH_COLON:  s.res = evt(cts_pkg::TOK_COLON);
			cts_pkg::CH_SEMI:   s.res = evt(cts_pkg::TOK_SEMI);
			cts_pkg::CH_COMMA:  s.res = evt(cts_pkg::TOK_COMMA);
			default: begin
				if (is_ws(c)) begin
					s.emit = 1'b0;
					s.mode = cts_pkg::MODE_WS;
				end else if (is_dig(c)) begin
					s.res  = chr(c);
					s.mode = cts_pkg::MODE_NUM;
				end else if (is_start(c)) begin
					s.res  = chr(c);
					s.mode = cts_pkg::MODE_IDENT;
				end
			end
		endcase
		return s;
	endfunction

	idle_t         sc;
	cts_pkg::res_t close_r;
	logic          close_v;
	logic [7:0]    c;

	assign c  = byte_value;
	assign sc = scan_idle(c);

	always_comb begin
		dec.cnt       = 2'd0;
		dec.r0        = chr(c);
		dec.r1        = chr(c);
		dec.next_mode = mode;
		close_v       = 1'b1;
		close_r       = evt(cts_pkg::TOK_EOF);
		if (end_of_input) begin
			case (mode)
				cts_pkg::MODE_WS:    close_r = evt(cts_pkg::TOK_WS);
				cts_pkg::MODE_DQ,
				cts_pkg::MODE_SQ:    close_r = evt(cts_pkg::TOK_BAD);
				cts_pkg::MODE_HASH:  close_r = evt(cts_pkg::TOK_HASH);
				cts_pkg::MODE_AT:    close_r = evt(cts_pkg::TOK_AT);
				cts_pkg::MODE_NUM:   close_r = evt(cts_pkg::TOK_NUM);
				cts_pkg::MODE_UNIT:  close_r = evt(cts_pkg::TOK_DIM);
				cts_pkg::MODE_IDENT: close_r = evt(cts_pkg::TOK_IDENT);
				cts_pkg::MODE_PDOT:  close_r = mk(1'b1, cts_pkg::TOK_DELIM, cts_pkg::CH_DOT);
				cts_pkg::MODE_PHASH: close_r = mk(1'b1, cts_pkg::TOK_DELIM, cts_pkg::CH_HASH);
				default:             close_v = 1'b0;
			endcase
			if (close_v) begin
				dec.r0  = close_r;
				dec.r1  = evt(cts_pkg::TOK_EOF);
				dec.cnt = 2'd2;
			end else begin
				dec.r0  = evt(cts_pkg::TOK_EOF);
				dec.cnt = 2'd1;
			end
			dec.next_mode = cts_pkg::MODE_IDLE;
		end else begin
			// close_r holds the event that ends the token when the byte does not belong
			close_v = 1'b0;
			case (mode)
				cts_pkg::MODE_WS: begin
					if (!is_ws(c)) begin
						close_v = 1'b1;
						close_r = evt(cts_pkg::TOK_WS);
					end
				end
				cts_pkg::MODE_DQ,
				cts_pkg::MODE_SQ: begin
					if (c == ((mode == cts_pkg::MODE_DQ) ? cts_pkg::CH_DQUOTE
						: cts_pkg::CH_SQUOTE)) begin
						dec.r0        = evt(cts_pkg::TOK_STR);
						dec.next_mode = cts_pkg::MODE_IDLE;
					end else begin
						dec.r0 = chr(c);
					end
					dec.cnt = 2'd1;
				end
				cts_pkg::MODE_HASH,
				cts_pkg::MODE_AT,
				cts_pkg::MODE_UNIT,
				cts_pkg::MODE_IDENT: begin
					if (mode == cts_pkg::MODE_IDENT && c == cts_pkg::CH_LPAREN) begin
						dec.r0        = evt(cts_pkg::TOK_FUNC);
						dec.cnt       = 2'd1;
						dec.next_mode = cts_pkg::MODE_IDLE;
					end else if (is_name(c)) begin
						dec.r0  = chr(c);
						dec.cnt = 2'd1;
					end else begin
						close_v = 1'b1;
						case (mode)
							cts_pkg::MODE_HASH: close_r = evt(cts_pkg::TOK_HASH);
							cts_pkg::MODE_AT:   close_r = evt(cts_pkg::TOK_AT);
							cts_pkg::MODE_UNIT: close_r = evt(cts_pkg::TOK_DIM);
							default:            close_r = evt(cts_pkg::TOK_IDENT);
						endcase
					end
				end
				cts_pkg::MODE_NUM: begin
					if (is_dig(c) || c == cts_pkg::CH_DOT) begin
						dec.r0  = chr(c);
						dec.cnt = 2'd1;
					end else if (c == cts_pkg::CH_PCT) begin
						dec.r0        = evt(cts_pkg::TOK_PCT);
						dec.cnt       = 2'd1;
						dec.next_mode = cts_pkg::MODE_IDLE;
					end else if (is_start(c)) begin
						dec.r0        = chr(c);
						dec.cnt       = 2'd1;
						dec.next_mode = cts_pkg::MODE_UNIT;
					end else begin
						close_v = 1'b1;
						close_r = evt(cts_pkg::TOK_NUM);
					end
				end
				cts_pkg::MODE_PDOT: begin
					if (is_dig(c)) begin
						dec.r0        = chr(cts_pkg::CH_DOT);
						dec.r1        = chr(c);
						dec.cnt       = 2'd2;
						dec.next_mode = cts_pkg::MODE_NUM;
					end else begin
						close_v = 1'b1;
						close_r = mk(1'b1, cts_pkg::TOK_DELIM, cts_pkg::CH_DOT);
					end
				end
				cts_pkg::MODE_PHASH: begin
					if (is_name(c)) begin
						dec.r0        = chr(c);
						dec.cnt       = 2'd1;
						dec.next_mode = cts_pkg::MODE_HASH;
					end else begin
						close_v = 1'b1;
						close_r = mk(1'b1, cts_pkg::TOK_DELIM, cts_pkg::CH_HASH);
					end
				end
				default: begin
					dec.r0        = sc.res;
					dec.cnt       = {1'b0, sc.emit};
					dec.next_mode = sc.mode;
				end
			endcase
			// token ended by this byte: emit the close, then rescan from idle
			if (close_v) begin
				dec.r0        = close_r;
				dec.r1        = sc.res;
				dec.cnt       = sc.emit ? 2'd2 : 2'd1;
				dec.next_mode = sc.mode;
			end
		end
		if (dec.cnt == 2'd1) dec.r0.last = 1'b1;
		if (dec.cnt == 2'd2) dec.r1.last = 1'b1;
	end

endmodule

// ----- sv/css_token_scanner_unit.sv -----
`timescale 1ns / 1ps
// css_token_scanner_unit: streaming css tokenizer, one byte per request
// a request is registered in the input stage, decoded, and its results are registered in the output queue
// throughput: one request per cycle while each gives at most one result and m_tready
// is high; a request that gives two results fills both entries of the output queue
// reset: arst_n clears the lexer mode to idle and empties input and output stages

module css_token_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] byte_value
	input  logic        s_tuser,  // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [4:0] token_type, [12:5] char_value, [15:13] zero
	output logic        m_tuser,  // [0] item_kind
	output logic        m_tlast   // last_of_run
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           eoi_s1;
	cts_pkg::mode_t mode_q;
	cts_pkg::dec_t  dec;

	// two-entry output queue, head in slot 0
	cts_pkg::res_t  out0_q, out1_q;
	logic [1:0]     cnt_q;

	logic           pop;
	logic [1:0]     kept;
	logic [2:0]     need;
	logic           s1_adv;
	cts_pkg::res_t  keep0;

	cts_decode u_decode (
		.mode         (mode_q),
		.byte_value   (byte_s1),
		.end_of_input (eoi_s1),
		.dec          (dec)
	);

	assign pop    = m_tvalid && m_tready;
	assign kept   = cnt_q - {1'b0, pop};
	assign need   = {1'b0, kept} + {1'b0, dec.cnt};
	assign s1_adv = valid_s1 && (need <= 3'd2);
	assign s_tready = !valid_s1 || s1_adv;
	assign keep0  = pop ? out1_q : out0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= cts_pkg::MODE_IDLE;
			cnt_q    <= 2'd0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (s1_adv) mode_q <= dec.next_mode;
			cnt_q <= s1_adv ? need[1:0] : kept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
		if (s1_adv && dec.cnt != 2'd0) begin
			case (kept)
				2'd0: begin
					out0_q <= dec.r0;
					out1_q <= dec.r1;
				end
				2'd1: begin
					out0_q <= keep0;
					out1_q <= dec.r0;
				end
				default: ;
			endcase
		end else if (pop) begin
			out0_q <= out1_q;
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {3'b000, out0_q.ch, out0_q.ttype};
	assign m_tuser  = out0_q.kind;
	assign m_tlast  = out0_q.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec.cnt != 2'd0 && cnt_q == 2'd2 && !m_tready |-> !s1_adv)
		else $error("output queue overrun");

	a_eof_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && eoi_s1 |=> mode_q == cts_pkg::MODE_IDLE)
		else $error("mode not idle after end of input");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && dec.cnt == 2'd2 |-> dec.r1.last && !dec.r0.last)
		else $error("last flag misplaced on a two-result request");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

endmodule
